### rtl/core/mlls_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mlls_pkg
// Shared types and constants for the linked list store with free list.
// ============================================================================
package mlls_pkg;

    localparam int DEF_NUM_LISTS = 16;
    localparam int DEF_NUM_NODES = 256;
    localparam int DEF_KEY_BITS  = 16;

    typedef enum logic [1:0] {
        ACT_HEAD   = 2'd0,
        ACT_TAIL   = 2'd1,
        ACT_REMOVE = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_UNKNOWN  = 3'd1,
        ST_DUP      = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  list_id;
        logic [15:0] item_key;
        logic        key_in_catalog;
    } cmd_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] node_slot;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_CMP,
        S_ALLOC,
        S_POP,
        S_LINK,
        S_TAIL,
        S_UNLINK,
        S_FREE,
        S_DONE
    } state_t;

endpackage

### rtl/core/multi_list_linked_store_with_free_list_core.sv
`timescale 1ns / 1ps
// ============================================================================
// multi_list_linked_store_with_free_list_core
// Several singly linked lists of keys sharing one node pool with a free list.
// ============================================================================
// A command word is taken when start is high and busy is low; one result word
// follows, shown for a single cycle while done is high, and it must be taken
// then since the block cannot hold it. Lists are walked through the node key
// and link memories one node per cycle. A command visits up to NUM_NODES nodes
// of the chosen list. An insert then takes a node from the free list or the
// unused part of the pool and links it in, and a removal unlinks the node and
// pushes it on the free list. A word rejected before the walk (unknown key,
// list id out of range or unused action) is answered without a walk. No
// clearing pass is needed after reset.
module multi_list_linked_store_with_free_list_core
    import mlls_pkg::*;
#(
    parameter int NUM_LISTS = DEF_NUM_LISTS,
    parameter int NUM_NODES = DEF_NUM_NODES,
    parameter int KEY_BITS  = DEF_KEY_BITS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output res_t result
);

    localparam int AW      = $clog2(NUM_NODES);
    localparam int PTR_W   = $clog2(NUM_NODES + 1);
    localparam int LIST_AW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_NODES);

    state_t state_reg, state_next;

    cmd_t                cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [PTR_W-1:0]    cur_reg, cur_next;
    logic [PTR_W-1:0]    prev_reg, prev_next;
    logic [PTR_W-1:0]    nxt_reg, nxt_next;
    logic [PTR_W-1:0]    steps_reg, steps_next;
    logic [PTR_W-1:0]    free_head_reg, free_head_next;
    logic [PTR_W-1:0]    top_reg, top_next;
    status_t             status_reg, status_next;
    logic [PTR_W-1:0]    slot_reg, slot_next;

    logic [PTR_W-1:0] head_reg [NUM_LISTS];
    logic [PTR_W-1:0] tail_reg [NUM_LISTS];
    logic             head_wr, tail_wr;
    logic [PTR_W-1:0] head_wdata, tail_wdata;

    // Node memories.
    logic                key_we, next_we;
    logic [AW-1:0]       key_waddr, next_waddr, rd_addr;
    logic [KEY_BITS-1:0] key_rd;
    logic [PTR_W-1:0]    next_wdata, next_rd;

    logic [LIST_AW-1:0] list_idx;
    logic [PTR_W-1:0]   head_cur, tail_cur, steps_inc;
    logic               in_range, is_insert, cur_ok, key_hit, walk_more;
    logic               free_ok, top_ok, head_ok, tail_ok;

    mlls_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (NUM_NODES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_reg),
        .raddr (rd_addr),
        .rdata (key_rd)
    );

    mlls_ram #(
        .WIDTH (PTR_W),
        .DEPTH (NUM_NODES)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (rd_addr),
        .rdata (next_rd)
    );

    assign list_idx  = LIST_AW'(cmd_reg.list_id);
    assign in_range  = 32'(cmd_reg.list_id) < 32'(NUM_LISTS);
    assign head_cur  = head_reg[list_idx];
    assign tail_cur  = tail_reg[list_idx];
    assign head_ok   = head_cur < NIL;
    assign tail_ok   = tail_cur < NIL;
    assign is_insert = (cmd_reg.action == ACT_HEAD) || (cmd_reg.action == ACT_TAIL);
    assign cur_ok    = (cur_reg < NIL) && (steps_reg < NIL);
    assign key_hit   = key_rd == key_reg;
    assign steps_inc = steps_reg + PTR_W'(1);
    assign walk_more = (next_rd < NIL) && (steps_inc < NIL);
    assign free_ok   = free_head_reg < NIL;
    assign top_ok    = top_reg < NIL;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!in_range)
                begin
                    state_next = S_DONE;
                end
                else if (is_insert)
                begin
                    state_next = cmd_reg.key_in_catalog ? S_WALK : S_DONE;
                end
                else if (cmd_reg.action == ACT_REMOVE)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WALK:
            begin
                if (cur_ok)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = is_insert ? S_ALLOC : S_DONE;
                end
            end
            S_CMP:
            begin
                if (key_hit)
                begin
                    state_next = is_insert ? S_DONE : S_UNLINK;
                end
                else if (!walk_more)
                begin
                    state_next = is_insert ? S_ALLOC : S_DONE;
                end
            end
            S_ALLOC:
            begin
                if (free_ok)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = top_ok ? S_LINK : S_DONE;
                end
            end
            S_POP:
            begin
                state_next = S_LINK;
            end
            S_LINK:
            begin
                if (cmd_reg.action == ACT_TAIL && head_ok && tail_ok)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_TAIL:
            begin
                state_next = S_DONE;
            end
            S_UNLINK:
            begin
                state_next = S_FREE;
            end
            S_FREE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        nxt_next       = nxt_reg;
        steps_next     = steps_reg;
        free_head_next = free_head_reg;
        top_next       = top_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        head_wr        = 1'b0;
        tail_wr        = 1'b0;
        head_wdata     = NIL;
        tail_wdata     = NIL;
        key_we         = 1'b0;
        next_we        = 1'b0;
        key_waddr      = AW'(cur_reg);
        next_waddr     = AW'(cur_reg);
        next_wdata     = NIL;
        rd_addr        = AW'(cur_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    key_next = KEY_BITS'(cmd.item_key);
                end
            end
            S_DECODE:
            begin
                status_next = ST_NOTFOUND;
                slot_next   = '0;
                if (in_range && is_insert && !cmd_reg.key_in_catalog)
                begin
                    status_next = ST_UNKNOWN;
                end
                cur_next   = head_cur;
                prev_next  = NIL;
                steps_next = '0;
            end
            S_CMP:
            begin
                if (key_hit)
                begin
                    if (is_insert)
                    begin
                        status_next = ST_DUP;
                    end
                    nxt_next = next_rd;
                end
                else if (walk_more)
                begin
                    // Address the following node at once so the walk keeps
                    // one node per cycle.
                    prev_next  = cur_reg;
                    cur_next   = next_rd;
                    steps_next = steps_inc;
                    rd_addr    = AW'(next_rd);
                end
            end
            S_ALLOC:
            begin
                if (free_ok)
                begin
                    cur_next = free_head_reg;
                    rd_addr  = AW'(free_head_reg);
                end
                else if (top_ok)
                begin
                    cur_next = top_reg;
                    top_next = top_reg + PTR_W'(1);
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            S_POP:
            begin
                free_head_next = next_rd;
            end
            S_LINK:
            begin
                key_we      = 1'b1;
                next_we     = 1'b1;
                status_next = ST_OK;
                slot_next   = cur_reg;
                if (cmd_reg.action == ACT_HEAD)
                begin
                    next_wdata = head_cur;
                    head_wr    = 1'b1;
                    head_wdata = cur_reg;
                    if (!tail_ok)
                    begin
                        tail_wr    = 1'b1;
                        tail_wdata = cur_reg;
                    end
                end
                else if (!head_ok)
                begin
                    head_wr    = 1'b1;
                    head_wdata = cur_reg;
                    tail_wr    = 1'b1;
                    tail_wdata = cur_reg;
                end
                else if (!tail_ok)
                begin
                    tail_wr    = 1'b1;
                    tail_wdata = cur_reg;
                end
            end
            S_TAIL:
            begin
                next_we    = 1'b1;
                next_waddr = AW'(tail_cur);
                next_wdata = cur_reg;
                tail_wr    = 1'b1;
                tail_wdata = cur_reg;
            end
            S_UNLINK:
            begin
                if (prev_reg == NIL)
                begin
                    head_wr = 1'b1;
                    if (nxt_reg < NIL)
                    begin
                        head_wdata = nxt_reg;
                    end
                    else
                    begin
                        tail_wr = 1'b1;
                    end
                end
                else
                begin
                    next_we    = 1'b1;
                    next_waddr = AW'(prev_reg);
                    next_wdata = nxt_reg;
                    if (tail_cur == cur_reg)
                    begin
                        tail_wr    = 1'b1;
                        tail_wdata = prev_reg;
                    end
                end
            end
            S_FREE:
            begin
                next_we        = 1'b1;
                next_wdata     = free_head_reg;
                free_head_next = cur_reg;
                status_next    = ST_OK;
                slot_next      = cur_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        busy             = state_reg != S_IDLE;
        done             = state_reg == S_DONE;
        result.status    = status_reg;
        result.node_slot = 8'(slot_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= NIL;
            top_reg       <= '0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            top_reg       <= top_next;
            if (head_wr)
            begin
                head_reg[list_idx] <= head_wdata;
            end
            if (tail_wr)
            begin
                tail_reg[list_idx] <= tail_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        nxt_reg    <= nxt_next;
        steps_reg  <= steps_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
    end

`ifndef NO_ASSERTIONS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result word shown for more than one cycle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command word taken but block not busy");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> result.node_slot == 8'd0)
        else $error("failed command reports a node slot");

    a_pool_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg <= NIL) && (top_reg <= NIL))
        else $error("free list head or top counter outside the pool");
`endif

endmodule

### rtl/core/mlls_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// mlls_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module mlls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
